FILE: rtl/rxfmr_pkg.sv
package rxfmr_pkg;

    // request codes
    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty_res;
        logic       overrun;
    } rsp_t;

    // start of one fetch, from the ring control to the fetch engine
    typedef struct packed {
        logic go;
        logic empty;
        logic ovr;
    } fetch_cmd_t;

endpackage

FILE: rtl/rx_fixed_message_ring.sv
// Receive message ring. Each request is either a received byte (mode 0) or a
// fetch (mode 1). Bytes are packed into MSG_LEN-byte slots of a ring of
// SLOT_COUNT slots held in one dual-port store (one write port, one read port
// with registered read data); a slot counts as a message once its last byte
// is in. A fetch returns the oldest message as MSG_LEN results, one per
// cycle while results are not stalled, the final one marked with last;
// with nothing waiting it returns a single result with empty_res set and
// zero data. When every slot is full an incoming byte is dropped and a
// sticky overrun flag is set, reported on all results of the next fetch
// and then cleared. A byte request is taken whenever the block is not
// fetching. A fetch keeps the request side stalled until its last result
// is loaded into the result register, paced by the store's single read
// port delivering one byte a cycle when not stalled. Results are registered,
// so requests carry on while the final result still waits to be taken.
module rx_fixed_message_ring #(
    parameter int MSG_LEN    = 4,
    parameter int SLOT_COUNT = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  rxfmr_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output rxfmr_pkg::rsp_t rsp
);

    import rxfmr_pkg::*;

    localparam int DEPTH  = MSG_LEN * SLOT_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

    // ring pointers and message count
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              overrun_reg, overrun_next;

    logic              accept;
    logic              busy;
    logic              full;
    logic              msg_done;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_base;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    fetch_cmd_t        cmd;

    // one fetch at a time; bytes are refused only while a fetch is running
    assign req_stall = busy;
    assign accept    = req_valid && !req_stall;

    assign full     = (count_reg == CNT_W'(SLOT_COUNT));
    assign msg_done = (pos_reg == POS_W'(MSG_LEN - 1));
    assign wr_addr  = ADDR_W'(wr_slot_reg) * ADDR_W'(MSG_LEN) + ADDR_W'(pos_reg);
    assign rd_base  = ADDR_W'(rd_slot_reg) * ADDR_W'(MSG_LEN);

    // the slot being filled is never a committed slot, so the write port and
    // the read port of a running fetch never touch the same entry
    assign wr_en = accept && (req.mode == MODE_BYTE) && !full;

    always_comb
    begin
        pos_next     = pos_reg;
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        count_next   = count_reg;
        overrun_next = overrun_reg;
        cmd          = '0;

        if (accept)
        begin
            case (req.mode)
                MODE_BYTE:
                begin
                    if (full)
                    begin
                        // ring full: drop the byte, remember the loss
                        overrun_next = 1'b1;
                    end
                    else if (msg_done)
                    begin
                        // last byte of the slot: commit it
                        pos_next     = '0;
                        wr_slot_next = (wr_slot_reg == SLOT_W'(SLOT_COUNT - 1)) ?
                                       '0 : wr_slot_reg + SLOT_W'(1);
                        count_next   = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                MODE_FETCH:
                begin
                    cmd.go       = 1'b1;
                    cmd.ovr      = overrun_reg;
                    overrun_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        cmd.empty = 1'b1;
                    end
                    else
                    begin
                        // free the oldest slot now; its bytes stay until rewritten
                        rd_slot_next = (rd_slot_reg == SLOT_W'(SLOT_COUNT - 1)) ?
                                       '0 : rd_slot_reg + SLOT_W'(1);
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    cmd = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            wr_slot_reg <= '0;
            rd_slot_reg <= '0;
            count_reg   <= '0;
            overrun_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            count_reg   <= count_next;
            overrun_reg <= overrun_next;
        end
    end

    // message store
    rxfmr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (req.rx_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // fetch engine: reads one byte a cycle into the result register while it is not stalled
    rxfmr_fetch #(
        .MSG_LEN (MSG_LEN),
        .ADDR_W  (ADDR_W)
    ) u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .base      (rd_base),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

FILE: rtl/rxfmr_ram.sv
module rxfmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rxfmr_fetch.sv
module rxfmr_fetch #(
    parameter int MSG_LEN = 4,
    parameter int ADDR_W  = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rxfmr_pkg::fetch_cmd_t cmd,
    input  logic [ADDR_W-1:0]    base,
    output logic                 busy,
    output logic                 rd_en,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [7:0]           rd_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rxfmr_pkg::rsp_t      rsp
);

    import rxfmr_pkg::*;

    localparam int RW = $clog2(MSG_LEN + 1);

    logic [RW-1:0]     rem_reg, rem_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              empty_pend_reg, empty_pend_next;
    logic              ovr_reg, ovr_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic out_free;
    logic load_ram;
    logic load_empty;
    logic issue;

    assign out_free   = !out_valid_reg || !rsp_stall;
    assign load_ram   = pend_reg && out_free;
    assign load_empty = empty_pend_reg && out_free;
    // the ram output holds until its byte is taken into the output register
    assign issue      = (rem_reg != '0) && (!pend_reg || load_ram);

    always_comb
    begin
        rem_next        = rem_reg;
        addr_next       = addr_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;
        empty_pend_next = empty_pend_reg;
        ovr_next        = ovr_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && rsp_stall;

        if (cmd.go)
        begin
            ovr_next = cmd.ovr;
            if (cmd.empty)
            begin
                empty_pend_next = 1'b1;
            end
            else
            begin
                rem_next  = RW'(MSG_LEN);
                addr_next = base;
            end
        end

        if (load_ram)
        begin
            out_next.data      = rd_data;
            out_next.last      = pend_last_reg;
            out_next.empty_res = 1'b0;
            out_next.overrun   = ovr_reg;
            out_valid_next     = 1'b1;
            pend_next          = 1'b0;
        end
        else if (load_empty)
        begin
            out_next.data      = '0;
            out_next.last      = 1'b1;
            out_next.empty_res = 1'b1;
            out_next.overrun   = ovr_reg;
            out_valid_next     = 1'b1;
            empty_pend_next    = 1'b0;
        end

        if (issue)
        begin
            rem_next       = rem_reg - RW'(1);
            addr_next      = addr_reg + ADDR_W'(1);
            pend_next      = 1'b1;
            pend_last_next = (rem_reg == RW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= '0;
            pend_reg       <= 1'b0;
            empty_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rem_reg        <= rem_next;
            pend_reg       <= pend_next;
            empty_pend_reg <= empty_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        pend_last_reg <= pend_last_next;
        ovr_reg       <= ovr_next;
        out_reg       <= out_next;
    end

    assign busy      = (rem_reg != '0) || pend_reg || empty_pend_reg;
    assign rd_en     = issue;
    assign rd_addr   = addr_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

FILE: rtl/rxfmr_chk.sv
module rxfmr_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input rxfmr_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input rxfmr_pkg::rsp_t rsp
);

    import rxfmr_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

    // an empty fetch gives a single zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.empty_res |-> rsp.last && (rsp.data == 8'd0))
    else $error("empty result malformed");

    // a fetch request occupies the block for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.mode == MODE_FETCH) |=> req_stall)
    else $error("fetch did not hold off requests");

    // a byte request leaves the block free for the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.mode == MODE_BYTE) |=> !req_stall)
    else $error("byte request stalled the block");

endmodule

bind rx_fixed_message_ring rxfmr_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: verif/tb.sv
`timescale 1ns / 100ps

// testbench for rx_fixed_message_ring
// requests are bytes or fetches; a behavioural copy of the slot ring predicts
// the results of every accepted request, and a checker process compares
// each accepted result with the oldest prediction
module tb;

    import rxfmr_pkg::*;

    // geometry of the ring under test
    localparam int MSG_LEN     = 4;
    localparam int SLOT_COUNT  = 8;
    // generous ceiling on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 200000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    rx_fixed_message_ring #(
        .MSG_LEN    (MSG_LEN),
        .SLOT_COUNT (SLOT_COUNT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // behavioural copy of the ring
    // ---------------------------------------------------------------------
    logic [7:0] ring_bytes [SLOT_COUNT][MSG_LEN];
    int         fill_pos;
    int         wr_slot;
    int         rd_slot;
    int         msg_count;
    logic       dropped_flag;

    // results still owed by the block, oldest first
    rsp_t       fetch_q [$];

    int         errors;
    int         cycle_count;
    // random idling on both sides while set
    bit         idle_on;
    // long receiver hold-off, picked up by the receiver process
    int         hold_len;

    task automatic clear_ring();
        fill_pos     = 0;
        wr_slot      = 0;
        rd_slot      = 0;
        msg_count    = 0;
        dropped_flag = 1'b0;
        fetch_q.delete();
    endtask

    // work out what one accepted request causes
    task automatic predict_ring(input req_t r);
        rsp_t e;
        if (r.mode == MODE_BYTE)
        begin
            // ring full: byte is lost, flag it
            if (msg_count >= SLOT_COUNT)
            begin
                dropped_flag = 1'b1;
            end
            else
            begin
                ring_bytes[wr_slot][fill_pos] = r.rx_byte;
                fill_pos++;
                // last byte of the slot commits the message
                if (fill_pos >= MSG_LEN)
                begin
                    fill_pos = 0;
                    wr_slot  = (wr_slot + 1) % SLOT_COUNT;
                    msg_count++;
                end
            end
        end
        else if (msg_count == 0)
        begin
            // nothing committed: one empty result
            e.data      = 8'h00;
            e.last      = 1'b1;
            e.empty_res = 1'b1;
            e.overrun   = dropped_flag;
            fetch_q.push_back(e);
            dropped_flag = 1'b0;
        end
        else
        begin
            for (int i = 0; i < MSG_LEN; i++)
            begin
                e.data      = ring_bytes[rd_slot][i];
                e.last      = (i == MSG_LEN - 1);
                e.empty_res = 1'b0;
                e.overrun   = dropped_flag;
                fetch_q.push_back(e);
            end
            dropped_flag = 1'b0;
            rd_slot = (rd_slot + 1) % SLOT_COUNT;
            msg_count--;
        end
    endtask

    // ---------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------

    // offer one request, optionally after an idle burst, and wait for it
    // to be taken; valid is left high so the next request can follow on
    task automatic send_req(input logic m, input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= '{mode: m, rx_byte: b};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        predict_ring(req);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(MODE_BYTE, b);
    endtask

    // the byte field of a fetch is don't-care, so it carries noise
    task automatic send_fetch();
        send_req(MODE_FETCH, 8'($urandom));
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (fetch_q.size() != 0) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------

    // receiver stall: long hold-off on request, random bursts otherwise
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold_len - 1) @(negedge clk);
                hold_len = 0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic report_field(input string name, input int want, input int got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endtask

    rsp_t want;

    // compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (fetch_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual %h", $time, rsp);
            end
            else
            begin
                want = fetch_q.pop_front();
                if (rsp.data !== want.data)
                    report_field("data", want.data, rsp.data);
                if (rsp.last !== want.last)
                    report_field("last", want.last, rsp.last);
                if (rsp.empty_res !== want.empty_res)
                    report_field("empty_res", want.empty_res, rsp.empty_res);
                if (rsp.overrun !== want.overrun)
                    report_field("overrun", want.overrun, rsp.overrun);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // fetch straight after reset: single empty result, no overrun
    task automatic test_fetch_when_empty();
        send_fetch();
        drain();
    endtask

    // one message with all-zero, all-one and alternating byte values, then the ring is empty again
    task automatic test_single_message();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_req(MODE_FETCH, 8'h00);
        send_req(MODE_FETCH, 8'hFF);
        drain();
    endtask

    // half-filled slot is not a message yet
    task automatic test_partial_message();
        send_byte(8'h01);
        send_byte(8'h80);
        send_fetch();
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_fetch();
        drain();
    endtask

    // receiver holds off for a long stretch while the sender fills every
    // slot, overruns the ring and queues fetches behind the stalled output
    task automatic test_full_ring_backpressure();
        hold_len = 300;
        for (int i = 0; i < SLOT_COUNT * MSG_LEN; i++)
            send_byte(8'($urandom));
        // ring full: these are dropped and flagged
        send_byte(8'hFF);
        send_byte(8'h00);
        send_fetch();
        send_fetch();
        // room for two messages again
        for (int i = 0; i < MSG_LEN; i++)
            send_byte(8'($urandom));
        send_fetch();
        // sender pauses until everything owed has come back
        drain();
        for (int i = 0; i < SLOT_COUNT + 1; i++)
            send_fetch();
        drain();
    endtask

    // random mix; fetch_pct steers between filling the ring and emptying it
    task automatic test_random_traffic(input int count, input int fetch_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < fetch_pct)
                send_fetch();
            else
                send_byte(8'($urandom));
        end
        drain();
    endtask

    initial
    begin
        errors      = 0;
        cycle_count = 0;
        hold_len    = 0;
        idle_on     = 1'b1;
        clear_ring();

        // reset held low at the start, released on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fetch_when_empty();
        test_single_message();
        test_partial_message();
        test_full_ring_backpressure();

        // byte-heavy: ring fills, overruns happen
        test_random_traffic(100, 12);
        // fetch-heavy: many empty results
        test_random_traffic(80, 45);
        // balanced
        test_random_traffic(50, 22);
        // last part runs flat out with no idling
        idle_on = 1'b0;
        test_random_traffic(57, 22);

        // let any stray result show up before the verdict
        repeat (20) @(posedge clk);
        if (errors == 0 && fetch_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: rx_fixed_message_ring.f
rtl/rxfmr_pkg.sv
rtl/rxfmr_ram.sv
rtl/rxfmr_fetch.sv
rtl/rx_fixed_message_ring.sv
rtl/rxfmr_chk.sv
verif/tb.sv
